/* rtl/mrsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsp_pkg
// Shared types and constants of the MIDI running-status parser.
// ----------------------------------------------------------------------------
package mrsp_pkg;

  // Event kinds on the result channel
  typedef enum logic [3:0] {
    KIND_NOTEOFF   = 4'd0,
    KIND_NOTEON    = 4'd1,
    KIND_KEYPRESS  = 4'd2,
    KIND_CONTROL   = 4'd3,
    KIND_PROGRAM   = 4'd4,
    KIND_CHANPRESS = 4'd5,
    KIND_PITCHBEND = 4'd6,
    KIND_SENSE     = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  // Message progress: boundary, status taken, first data byte held
  typedef enum logic [1:0] {
    DS_IDLE   = 2'd0,
    DS_STATUS = 2'd1,
    DS_HELD   = 2'd2
  } data_seen_t;

  localparam logic [7:0]  STATUS_NONE  = 8'h00;
  localparam logic [7:0]  STATUS_SENSE = 8'hFE;
  localparam logic [3:0]  HI_SYSTEM    = 4'hF;
  localparam logic [3:0]  HI_PROGRAM   = 4'hC;
  localparam logic [3:0]  HI_CHANPRESS = 4'hD;
  localparam logic [3:0]  HI_BEND      = 4'hE;
  localparam logic [15:0] BEND_CENTER  = 16'd8192;

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic [7:0] port;
  } in_item_t;

  // One result request
  typedef struct packed {
    kind_t              event_kind;
    logic [3:0]         channel;
    logic [7:0]         first_value;
    logic [7:0]         second_value;
    logic signed [15:0] bend_value;
    logic [7:0]         source_port;
  } result_t;

endpackage
`default_nettype wire

/* rtl/mrsp_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsp_in_reg
// Input register: captures one request and holds it until the core steps.
// ----------------------------------------------------------------------------
module mrsp_in_reg
  import mrsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_packet_start,
  input  wire logic [7:0] in_port,
  input  wire logic       advance,
  output logic            item_valid,
  output in_item_t        item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     take;

  // Free slot, or the held request leaves this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{data_byte: in_data_byte, packet_start: in_packet_start, port: in_port};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* rtl/mrsp_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsp_core
// Running-status state and single-pass decode of one byte per step.
// ----------------------------------------------------------------------------
module mrsp_core
  import mrsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t item,
  output logic          res_valid,
  output result_t       res
);

  logic [7:0] rs_r, rs_nxt;
  data_seen_t ds_r, ds_nxt;
  logic [7:0] held_r, held_nxt;
  logic       disc_r, disc_nxt;

  logic [7:0] rs_v;
  data_seen_t ds_v;
  logic       disc_v;
  logic [7:0] byte_in;

  function automatic logic is_channel(input logic [7:0] s);
    return s[7] && (s[7:4] != HI_SYSTEM);
  endfunction

  function automatic logic needs_two(input logic [7:0] s);
    return (s[7:4] != HI_PROGRAM) && (s[7:4] != HI_CHANPRESS);
  endfunction

  // Complete a channel message under status s
  function automatic result_t finish(input logic [7:0] s, input logic [7:0] a,
                                     input logic [7:0] b, input logic [7:0] p);
    result_t r;
    r.event_kind   = kind_t'({1'b0, s[6:4]});
    r.channel      = s[3:0];
    r.source_port  = p;
    if (s[7:4] == HI_BEND) begin
      r.first_value  = '0;
      r.second_value = '0;
      r.bend_value   = $signed({1'b0, b, 7'b0} + {8'b0, a} - BEND_CENTER);
    end else begin
      r.first_value  = a;
      r.second_value = b;
      r.bend_value   = '0;
    end
    return r;
  endfunction

  assign byte_in = item.data_byte;

  // Packet start clears status, progress and discard before decode
  always_comb begin
    rs_v   = item.packet_start ? STATUS_NONE : rs_r;
    ds_v   = item.packet_start ? DS_IDLE : ds_r;
    disc_v = item.packet_start ? 1'b0 : disc_r;
  end

  // Decode
  always_comb begin
    rs_nxt    = rs_r;
    ds_nxt    = ds_r;
    held_nxt  = held_r;
    disc_nxt  = disc_r;
    res_valid = 1'b0;
    res       = '{event_kind: KIND_ERROR, channel: '0, first_value: '0,
                  second_value: '0, bend_value: '0, source_port: item.port};
    if (step_en) begin
      rs_nxt   = rs_v;
      ds_nxt   = ds_v;
      disc_nxt = disc_v;
      if (!disc_v) begin
        case (ds_v)
          DS_STATUS: begin
            if (needs_two(rs_v)) begin
              held_nxt = byte_in;
              ds_nxt   = DS_HELD;
            end else begin
              res       = finish(rs_v, byte_in, 8'h00, item.port);
              res_valid = 1'b1;
              ds_nxt    = DS_IDLE;
            end
          end
          DS_HELD: begin
            res       = finish(rs_v, held_r, byte_in, item.port);
            res_valid = 1'b1;
            ds_nxt    = DS_IDLE;
          end
          default: begin
            // Message boundary
            ds_nxt = DS_IDLE;
            if (byte_in[7]) begin
              rs_nxt = byte_in;
              if (byte_in == STATUS_SENSE) begin
                res.event_kind = KIND_SENSE;
                res_valid      = 1'b1;
              end else if (!is_channel(byte_in)) begin
                res_valid = 1'b1;
                disc_nxt  = 1'b1;
              end else begin
                ds_nxt = DS_STATUS;
              end
            end else if (!is_channel(rs_v)) begin
              // No usable running status
              res_valid = 1'b1;
              disc_nxt  = 1'b1;
            end else if (needs_two(rs_v)) begin
              held_nxt = byte_in;
              ds_nxt   = DS_HELD;
            end else begin
              res       = finish(rs_v, byte_in, 8'h00, item.port);
              res_valid = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r   <= STATUS_NONE;
      ds_r   <= DS_IDLE;
      held_r <= 8'h00;
      disc_r <= 1'b0;
    end else begin
      rs_r   <= rs_nxt;
      ds_r   <= ds_nxt;
      held_r <= held_nxt;
      disc_r <= disc_nxt;
    end
  end

  // While discarding within a packet, no byte yields a result
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && disc_r && !item.packet_start |-> !res_valid)
    else $error("result produced while discarding");

  // An error result always leaves the parser discarding
  a_error_discards: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && (res.event_kind == KIND_ERROR) |=> disc_r)
    else $error("error result without discard");

  // Mid-message means the running status is a channel status
  a_mid_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (ds_r != DS_IDLE) |-> (rs_r[7] && (rs_r[7:4] != HI_SYSTEM)))
    else $error("mid-message under non-channel status");

  // Discarding never coexists with an open message
  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (ds_r == DS_IDLE))
    else $error("discard with open message");

endmodule
`default_nettype wire

/* rtl/mrsp_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrsp_out_reg
// Result register: holds one decoded event until the consumer takes it.
// ----------------------------------------------------------------------------
module mrsp_out_reg
  import mrsp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         advance,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Core may step when the slot is empty or being emptied
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = advance ? res_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/midi_running_status_parser_unit.sv */
// Takes one MIDI byte per cycle unless stalled and returns at most one decoded
// event per byte: an input register feeds single-pass decode logic, which
// writes a result register once that is free, so a request can be accepted
// every cycle while the consumer keeps up. in_ready drops only while the
// result register holds an event that the consumer has not taken and the input
// register is also full. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midi_running_status_parser_unit
// Top level of the MIDI running-status parser.
// ----------------------------------------------------------------------------
module midi_running_status_parser_unit
  import mrsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_packet_start,
  input  wire logic [7:0]  in_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_event_kind,
  output logic [3:0]       out_channel,
  output logic [7:0]       out_first_value,
  output logic [7:0]       out_second_value,
  output logic signed [15:0] out_bend_value,
  output logic [7:0]       out_source_port
);

  logic     advance;
  logic     item_valid;
  in_item_t item;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  mrsp_in_reg u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_packet_start (in_packet_start),
    .in_port         (in_port),
    .advance         (advance),
    .item_valid      (item_valid),
    .item            (item)
  );

  mrsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (item_valid && advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mrsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_kind   = 4'(out_res.event_kind);
  assign out_channel      = out_res.channel;
  assign out_first_value  = out_res.first_value;
  assign out_second_value = out_res.second_value;
  assign out_bend_value   = out_res.bend_value;
  assign out_source_port  = out_res.source_port;

endmodule
`default_nettype wire
